[rtl/fdl_pkg.sv]
// Fractional delay line: shared widths, reset values and inter-module types.
// No dependencies; imported by the top level and the interpolator.
`default_nettype none

package fdl_pkg;

   localparam int BASE_WIDTH   = 12;
   localparam int OFFSET_WIDTH = 21;

   localparam logic [BASE_WIDTH-1:0] BASE_RESET = BASE_WIDTH'(1);

   // Stage-two control handed from the top level to the interpolator.
   typedef struct packed {
      logic vld;
      logic fwd_older;
      logic fwd_newer;
   } fdl_sel_type;

endpackage

`default_nettype wire

[rtl/fdl_sample_store.sv]
// Fractional delay line: circular sample memory, write pointer, tap address
// generation and the clearing pass after reset. Standalone, no package use.
`default_nettype none

module fdl_sample_store #(
   parameter int MAX_DELAY    = 4095,
   parameter int SAMPLE_WIDTH = 24,
   localparam int PTR_W       = $clog2(MAX_DELAY + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    issue,
   input  logic [SAMPLE_WIDTH-1:0] wr_sample,
   input  logic [PTR_W-1:0]        tap_dist,
   output logic                    clr_busy,
   output logic [SAMPLE_WIDTH-1:0] rd_older,
   output logic [SAMPLE_WIDTH-1:0] rd_newer
);

   localparam int DEPTH                 = MAX_DELAY + 1;
   localparam logic [PTR_W:0] DEPTH_EXT = (PTR_W + 1)'(DEPTH);
   localparam logic [PTR_W-1:0] LAST    = PTR_W'(MAX_DELAY);

   logic [SAMPLE_WIDTH-1:0] mem [DEPTH];

   logic [PTR_W-1:0]        wp_ff, wp_in;
   logic                    clr_busy_ff, clr_busy_in;
   logic [PTR_W-1:0]        clr_addr_ff, clr_addr_in;
   logic [SAMPLE_WIDTH-1:0] rd_older_ff, rd_newer_ff;

   logic [PTR_W:0]          diff, wrapped;
   logic [PTR_W-1:0]        older_addr, newer_addr;
   logic                    we;
   logic [PTR_W-1:0]        waddr;
   logic [SAMPLE_WIDTH-1:0] wdata;

   // Older tap sits tap_dist entries behind the write pointer, modulo depth.
   always_comb begin
      diff       = {1'b0, wp_ff} - {1'b0, tap_dist};
      wrapped    = diff + DEPTH_EXT;
      older_addr = diff[PTR_W] ? wrapped[PTR_W-1:0] : diff[PTR_W-1:0];
      newer_addr = (older_addr == LAST) ? '0 : older_addr + PTR_W'(1);
   end

   always_comb begin
      wp_in       = wp_ff;
      clr_addr_in = clr_addr_ff;
      clr_busy_in = clr_busy_ff;
      if (issue) begin
         wp_in = (wp_ff == LAST) ? '0 : wp_ff + PTR_W'(1);
      end
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + PTR_W'(1);
         clr_busy_in = (clr_addr_ff != LAST);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff       <= '0;
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         wp_ff       <= wp_in;
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   assign we    = clr_busy_ff || issue;
   assign waddr = clr_busy_ff ? clr_addr_ff : wp_ff;
   assign wdata = clr_busy_ff ? '0 : wr_sample;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Read data holds until the next issue so a stalled stage keeps its taps.
   always_ff @(posedge clock) begin
      if (issue) begin
         rd_older_ff <= mem[older_addr];
         rd_newer_ff <= mem[newer_addr];
      end
   end

   assign clr_busy = clr_busy_ff;
   assign rd_older = rd_older_ff;
   assign rd_newer = rd_newer_ff;

endmodule

`default_nettype wire

[rtl/fdl_interp.sv]
// Fractional delay line: tap forwarding, weighted products, sum, shift and
// the result register. Uses fdl_pkg for the stage-two control struct.
`default_nettype none

module fdl_interp
   import fdl_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 24,
   parameter int FRAC_BITS    = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  fdl_sel_type                    sel,
   input  logic signed [SAMPLE_WIDTH-1:0] cur_sample,
   input  logic signed [SAMPLE_WIDTH-1:0] rd_older,
   input  logic signed [SAMPLE_WIDTH-1:0] rd_newer,
   input  logic [FRAC_BITS:0]             w_older,
   input  logic [FRAC_BITS-1:0]           w_newer,
   output logic                           take,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_sample_out
);

   localparam int PW = SAMPLE_WIDTH + FRAC_BITS + 2;

   logic signed [SAMPLE_WIDTH-1:0] older, newer;
   logic signed [FRAC_BITS+1:0]    w_older_s;
   logic signed [FRAC_BITS:0]      w_newer_s;
   logic signed [PW-1:0]           p_older_in, p_newer_in;
   logic signed [PW-1:0]           p_older_ff, p_newer_ff;
   logic                           s3_vld_ff, s3_vld_in;
   logic                           rsp_vld_ff, rsp_vld_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_data_ff;
   logic signed [PW-1:0]           sum, shifted;
   logic                           out_free, s3_go, s3_free;

   // The sample written in the same transaction is not in memory read data yet.
   assign older     = sel.fwd_older ? cur_sample : rd_older;
   assign newer     = sel.fwd_newer ? cur_sample : rd_newer;
   assign w_older_s = {1'b0, w_older};
   assign w_newer_s = {1'b0, w_newer};

   assign p_older_in = PW'(older) * PW'(w_older_s);
   assign p_newer_in = PW'(newer) * PW'(w_newer_s);

   assign out_free = !rsp_vld_ff || !rsp_stall;
   assign s3_go    = s3_vld_ff && out_free;
   assign s3_free  = !s3_vld_ff || s3_go;
   assign take     = sel.vld && s3_free;

   always_comb begin
      s3_vld_in = s3_vld_ff;
      if (take) begin
         s3_vld_in = 1'b1;
      end else if (s3_go) begin
         s3_vld_in = 1'b0;
      end
      rsp_vld_in = rsp_vld_ff;
      if (s3_go) begin
         rsp_vld_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_vld_in = 1'b0;
      end
   end

   // Floor rounding: arithmetic shift of the exact sum.
   assign sum     = p_older_ff + p_newer_ff;
   assign shifted = sum >>> FRAC_BITS;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff  <= s3_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         p_older_ff <= p_older_in;
         p_newer_ff <= p_newer_in;
      end
      if (s3_go) begin
         rsp_data_ff <= shifted[SAMPLE_WIDTH-1:0];
      end
   end

   assign rsp_valid      = rsp_vld_ff;
   assign rsp_sample_out = rsp_data_ff;

endmodule

`default_nettype wire

[rtl/fractional_delay_line_top.sv]
// Linear-interpolated fractional delay line. Each transaction on the req_
// channel writes one sample into a circular memory of MAX_DELAY+1 entries and
// returns on the rsp_ channel the two-tap linear interpolation at a delay of
// base_delay + mod_offset/2^FRAC_BITS samples, clamped to 0..MAX_DELAY. The
// block takes one transaction per clock cycle while req_stall is low, set by
// the memory's one write and two read ports per cycle; a result passes the
// stage-one, stage-two, product and result registers before rsp_ shows it.
// After reset a clearing pass zeroes all MAX_DELAY+1 memory entries, one per
// cycle, with req_stall high throughout; csr_ writes are taken at any time and
// act on the next transaction. Depends on fdl_pkg, fdl_sample_store, fdl_interp.
`default_nettype none

module fractional_delay_line_top
   import fdl_pkg::*;
#(
   parameter int MAX_DELAY    = 4095,
   parameter int FRAC_BITS    = 8,
   parameter int SAMPLE_WIDTH = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_in,
   input  logic signed [OFFSET_WIDTH-1:0] req_mod_offset,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_sample_out,
   input  logic                           csr_wr_en,
   input  logic [BASE_WIDTH-1:0]          csr_wr_data
);

   localparam int PTR_W = $clog2(MAX_DELAY + 1);
   localparam int W_A   = BASE_WIDTH + FRAC_BITS;
   localparam int W_C   = PTR_W + FRAC_BITS;
   localparam int W_AB  = (W_A > OFFSET_WIDTH) ? W_A : OFFSET_WIDTH;
   localparam int DW    = ((W_AB > W_C) ? W_AB : W_C) + 2;
   localparam int DLY_W = PTR_W + FRAC_BITS;

   localparam logic signed [DW-1:0] DMAX = DW'(MAX_DELAY) <<< FRAC_BITS;

   logic [BASE_WIDTH-1:0] base_ff;

   logic signed [DW-1:0]   base_term, off_ext, d_raw, d_sat;
   logic [DLY_W-1:0]       d_u;
   logic [FRAC_BITS-1:0]   frac;
   logic [PTR_W-1:0]       dist_in;
   logic [FRAC_BITS:0]     w_older_in;
   logic [FRAC_BITS-1:0]   w_newer_in;

   logic                           s1_vld_ff, s1_vld_in;
   logic signed [SAMPLE_WIDTH-1:0] s1_sample_ff;
   logic [PTR_W-1:0]               s1_dist_ff;
   logic [FRAC_BITS:0]             s1_w_older_ff;
   logic [FRAC_BITS-1:0]           s1_w_newer_ff;

   logic                           s2_vld_ff, s2_vld_in;
   logic signed [SAMPLE_WIDTH-1:0] s2_sample_ff;
   logic [FRAC_BITS:0]             s2_w_older_ff;
   logic [FRAC_BITS-1:0]           s2_w_newer_ff;
   logic                           s2_fwd_older_ff, s2_fwd_newer_ff;

   logic                           accept, s1_go, s1_free, s2_free, s2_take;
   logic                           clr_busy;
   logic signed [SAMPLE_WIDTH-1:0] rd_older, rd_newer;
   fdl_sel_type                    sel;

   // Delay in fractional samples, clamped, split into ceiling and weights.
   always_comb begin
      base_term = signed'(DW'(base_ff) << FRAC_BITS);
      off_ext   = DW'(req_mod_offset);
      d_raw     = base_term + off_ext;
      if (d_raw[DW-1]) begin
         d_sat = '0;
      end else if (d_raw > DMAX) begin
         d_sat = DMAX;
      end else begin
         d_sat = d_raw;
      end
      d_u        = d_sat[DLY_W-1:0];
      frac       = d_u[FRAC_BITS-1:0];
      dist_in    = d_u[DLY_W-1:FRAC_BITS] + PTR_W'(frac != '0);
      w_older_in = (frac == '0) ? {1'b1, {FRAC_BITS{1'b0}}} : {1'b0, frac};
      w_newer_in = ~frac + FRAC_BITS'(1);
   end

   assign s2_free   = !s2_vld_ff || s2_take;
   assign s1_go     = s1_vld_ff && s2_free;
   assign s1_free   = !s1_vld_ff || s1_go;
   assign req_stall = clr_busy || !s1_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (accept) begin
         s1_vld_in = 1'b1;
      end else if (s1_go) begin
         s1_vld_in = 1'b0;
      end
      s2_vld_in = s2_vld_ff;
      if (s1_go) begin
         s2_vld_in = 1'b1;
      end else if (s2_take) begin
         s2_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= BASE_RESET;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            base_ff <= csr_wr_data;
         end
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff  <= req_sample_in;
         s1_dist_ff    <= dist_in;
         s1_w_older_ff <= w_older_in;
         s1_w_newer_ff <= w_newer_in;
      end
      if (s1_go) begin
         s2_sample_ff    <= s1_sample_ff;
         s2_w_older_ff   <= s1_w_older_ff;
         s2_w_newer_ff   <= s1_w_newer_ff;
         s2_fwd_older_ff <= (s1_dist_ff == PTR_W'(0));
         s2_fwd_newer_ff <= (s1_dist_ff == PTR_W'(1));
      end
   end

   fdl_sample_store #(
      .MAX_DELAY    (MAX_DELAY),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_fdl_sample_store (
      .clock     (clock),
      .reset     (reset),
      .issue     (s1_go),
      .wr_sample (s1_sample_ff),
      .tap_dist  (s1_dist_ff),
      .clr_busy  (clr_busy),
      .rd_older  (rd_older),
      .rd_newer  (rd_newer)
   );

   assign sel.vld       = s2_vld_ff;
   assign sel.fwd_older = s2_fwd_older_ff;
   assign sel.fwd_newer = s2_fwd_newer_ff;

   fdl_interp #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .FRAC_BITS    (FRAC_BITS)
   ) u_fdl_interp (
      .clock          (clock),
      .reset          (reset),
      .sel            (sel),
      .cur_sample     (s2_sample_ff),
      .rd_older       (rd_older),
      .rd_newer       (rd_newer),
      .w_older        (s2_w_older_ff),
      .w_newer        (s2_w_newer_ff),
      .take           (s2_take),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out)
   );

endmodule

`default_nettype wire

[rtl/fdl_checker.sv]
// Fractional delay line: port-level checks over time, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module fdl_checker #(
   parameter int SAMPLE_WIDTH = 24
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [SAMPLE_WIDTH-1:0] rsp_sample_out
);

   logic [2:0] pend_ff, pend_in;
   logic       acc, dlv;

   assign acc = req_valid && !req_stall;
   assign dlv = rsp_valid && !rsp_stall;

   // Count transactions accepted but not yet delivered.
   always_comb begin
      pend_in = pend_ff + 3'(acc) - 3'(dlv);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_clear_after_reset: assert property (@(posedge clock) reset |=> req_stall)
      else $error("input not stalled during clearing pass");

   a_no_rsp_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample_out))
      else $error("stalled result changed or dropped");

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= 3'd4)
      else $error("more transactions in flight than pipeline stages");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 3'd0)
      else $error("result without a pending transaction");

endmodule

bind fractional_delay_line_top fdl_checker #(
   .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_fdl_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_sample_out (rsp_sample_out)
);

`default_nettype wire
